@@ hw/rtl/iale_pkg.sv @@
// Shared types, codes and sizes for the indexed array list engine.
package iale_pkg;

  localparam int CAPACITY = 128;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_INSERT_AT  = 3'd1,
    OP_DELETE_AT  = 3'd2,
    OP_PUSH_FRONT = 3'd3,
    OP_PUSH_BACK  = 3'd4,
    OP_POP_FRONT  = 3'd5,
    OP_POP_BACK   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_PUT
  } cmd_kind_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_GATHER
  } fsm_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [7:0]         entry_count;
  } out_item_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [CNT_W-1:0] at;
    logic [CNT_W-1:0] sel;
    logic [31:0] word;
  } cmd_t;

endpackage

@@ hw/rtl/iale_cell.sv @@
// One list slot: holds one word and trades it with its neighbors on shifts.
module iale_cell (
  input  logic              clk,
  input  logic [iale_pkg::CNT_W-1:0] idx,
  input  iale_pkg::cmd_t    cmd,
  input  logic [31:0]       lower_value,
  input  logic [31:0]       upper_value,
  output logic [31:0]       value,
  output logic [31:0]       tap
);
  import iale_pkg::*;

  logic [31:0] value_r;
  logic [31:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (cmd.kind)
      CMD_OPEN: begin
        if (idx > cmd.at) begin
          value_nxt = lower_value;
        end else if (idx == cmd.at) begin
          value_nxt = cmd.word;
        end
      end
      CMD_CLOSE: begin
        if (idx >= cmd.at) begin
          value_nxt = upper_value;
        end
      end
      CMD_PUT: begin
        if (idx == cmd.at) begin
          value_nxt = cmd.word;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  // Offer the stored word to the read tree only when selected.
  assign tap   = (idx == cmd.sel) ? value_r : 32'd0;

endmodule

@@ hw/rtl/iale_gather.sv @@
// Two-level OR tree that collects the selected cell's word.
module iale_gather (
  input  logic        clk,
  input  logic        capture,
  input  logic [31:0] taps [iale_pkg::CAPACITY],
  output logic [31:0] word
);
  import iale_pkg::*;

  logic [31:0] group_r   [NGROUP];
  logic [31:0] group_nxt [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_nxt[g] = 32'd0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          group_nxt[g] = group_nxt[g] | taps[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      group_r <= group_nxt;
    end
  end

  always_comb begin
    word = 32'd0;
    for (int g = 0; g < NGROUP; g++) begin
      word = word | group_r[g];
    end
  end

endmodule

@@ hw/rtl/indexed_array_list_engine.sv @@
// Top level of the indexed array list engine: cell row, read tree and control.
//
// An ordered list of up to 128 signed 32-bit words, held one word per cell in
// a row of cells. Each request beat names read, insert at, delete at, push
// front, push back, pop front or pop back and returns exactly one result beat
// with a status (ok, bad index, full, empty), the word read or popped from the
// back (-1 on any error, 0 for other successful operations) and the entry
// count after the request. In the accept cycle all cells shift or load at
// once and the selected word enters the first level of the read OR tree;
// once the output register is free or being drained, the tree's last level
// finishes and the result is written into the output register. A new request
// is accepted only in idle, once the last result is in the output register;
// a result may wait there while the next request is being worked on.
// An insert into a full list reports bad index; code seven is a no-op with ok.
module indexed_array_list_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iale_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iale_pkg::out_item_t out_data
);
  import iale_pkg::*;

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic             use_read_r, use_read_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             accept;
  logic             load_out;
  cmd_t             cmd;
  logic [CNT_W-1:0] pos;
  logic             full;
  logic             empty;
  logic [31:0]      cell_value [CAPACITY];
  logic [31:0]      cell_tap   [CAPACITY];
  logic [31:0]      gathered;

  assign pos    = CNT_W'(in_data.position);
  assign full   = (count_r >= CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign accept = in_valid && !in_stall;

  // Decode the request: the command for the row, the status and new count.
  always_comb begin
    cmd.kind     = CMD_HOLD;
    cmd.at       = pos;
    cmd.sel      = pos;
    cmd.word     = in_data.item_value;
    status_nxt   = STAT_OK;
    use_read_nxt = 1'b0;
    count_nxt    = count_r;
    case (in_data.op)
      OP_READ: begin
        if (pos >= count_r) begin
          status_nxt = STAT_BAD_INDEX;
        end else begin
          use_read_nxt = 1'b1;
        end
      end
      OP_INSERT_AT: begin
        if (pos > count_r || full) begin
          status_nxt = STAT_BAD_INDEX;
        end else begin
          cmd.kind  = CMD_OPEN;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (pos >= count_r) begin
          status_nxt = STAT_BAD_INDEX;
        end else begin
          cmd.kind  = CMD_CLOSE;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          cmd.kind  = CMD_OPEN;
          cmd.at    = '0;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          cmd.kind  = CMD_PUT;
          cmd.at    = count_r;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          cmd.kind  = CMD_CLOSE;
          cmd.at    = '0;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          cmd.sel      = count_r - 1'b1;
          use_read_nxt = 1'b1;
          count_nxt    = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
    // Hold every cell unless a beat is taken this cycle.
    if (!accept) begin
      cmd.kind = CMD_HOLD;
    end
  end

  // Row of cells; the ends see their own word or the new word as neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] lower_value;
    logic [31:0] upper_value;
    if (i == 0) begin : g_first
      assign lower_value = cmd.word;
    end else begin : g_mid_lo
      assign lower_value = cell_value[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_value = cell_value[i];
    end else begin : g_mid_hi
      assign upper_value = cell_value[i + 1];
    end
    iale_cell u_cell (
      .clk         (clk),
      .idx         (CNT_W'(i)),
      .cmd         (cmd),
      .lower_value (lower_value),
      .upper_value (upper_value),
      .value       (cell_value[i]),
      .tap         (cell_tap[i])
    );
  end

  // First tree level registers at the accept edge, before the row changes.
  iale_gather u_gather (
    .clk     (clk),
    .capture (accept),
    .taps    (cell_tap),
    .word    (gathered)
  );

  // Next state and handshake: take a beat in idle, finish it once the output
  // register is free or being drained.
  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = FSM_GATHER;
        end
      end
      FSM_GATHER: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = status_r;
      out_data_nxt.entry_count = 8'(count_r);
      if (status_r != STAT_OK) begin
        out_data_nxt.read_value = -32'sd1;
      end else if (use_read_r) begin
        out_data_nxt.read_value = gathered;
      end else begin
        out_data_nxt.read_value = 32'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      status_r   <= status_nxt;
      use_read_r <= use_read_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ test/list_result_checker.sv @@
// Result checker for the indexed array list engine: predicts every result beat and compares it.
`timescale 1ns / 100ps

module list_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  iale_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  iale_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_beats,
  output int                  list_size
);
  import iale_pkg::*;

  localparam logic signed [31:0] ERR_WORD = -32'sd1;
  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] list_words [CAPACITY];
  int unsigned        occupancy;
  out_item_t          awaited_results [$];
  int                 results_seen;

  initial begin
    fail_count    = 0;
    pending_beats = 0;
    list_size     = 0;
    occupancy     = 0;
    results_seen  = 0;
  end

  // Move entries at and after 'at' one place up.
  function automatic void open_slot(input int unsigned at);
    for (int unsigned i = occupancy; i > at; i--) begin
      list_words[i] = list_words[i - 1];
    end
  endfunction

  // Move entries after 'at' one place down.
  function automatic void close_slot(input int unsigned at);
    for (int unsigned i = at; i + 1 < occupancy; i++) begin
      list_words[i] = list_words[i + 1];
    end
  endfunction

  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t   res;
    int unsigned pos;
    res.status     = STAT_OK;
    res.read_value = '0;
    pos            = req.position;
    case (req.op)
      OP_READ: begin
        if (pos >= occupancy) begin
          res.status     = STAT_BAD_INDEX;
          res.read_value = ERR_WORD;
        end else begin
          res.read_value = list_words[pos];
        end
      end
      OP_INSERT_AT: begin
        if (pos > occupancy || occupancy >= CAPACITY) begin
          res.status     = STAT_BAD_INDEX;
          res.read_value = ERR_WORD;
        end else begin
          open_slot(pos);
          list_words[pos] = req.item_value;
          occupancy++;
        end
      end
      OP_DELETE_AT: begin
        if (pos >= occupancy) begin
          res.status     = STAT_BAD_INDEX;
          res.read_value = ERR_WORD;
        end else begin
          close_slot(pos);
          occupancy--;
        end
      end
      OP_PUSH_FRONT: begin
        if (occupancy >= CAPACITY) begin
          res.status     = STAT_FULL;
          res.read_value = ERR_WORD;
        end else begin
          open_slot(0);
          list_words[0] = req.item_value;
          occupancy++;
        end
      end
      OP_PUSH_BACK: begin
        if (occupancy >= CAPACITY) begin
          res.status     = STAT_FULL;
          res.read_value = ERR_WORD;
        end else begin
          list_words[occupancy] = req.item_value;
          occupancy++;
        end
      end
      OP_POP_FRONT: begin
        if (occupancy == 0) begin
          res.status     = STAT_EMPTY;
          res.read_value = ERR_WORD;
        end else begin
          close_slot(0);
          occupancy--;
        end
      end
      OP_POP_BACK: begin
        if (occupancy == 0) begin
          res.status     = STAT_EMPTY;
          res.read_value = ERR_WORD;
        end else begin
          res.read_value = list_words[occupancy - 1];
          occupancy--;
        end
      end
      default: ;
    endcase
    res.entry_count = occupancy[7:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        errors;
    errors = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_request(in_data));
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (fail_count + errors <= REPORT_LIMIT) begin
            $display("%0t: result beat %0d arrived with nothing outstanding", $realtime,
                     results_seen);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status || out_data.read_value !== want.read_value ||
              out_data.entry_count !== want.entry_count) begin
            errors++;
            if (fail_count + errors <= REPORT_LIMIT) begin
              $display("%0t: result beat %0d: expected status %0d value %0d count %0d,",
                       $realtime, results_seen, want.status, want.read_value,
                       want.entry_count);
              $display("    got status %0d value %0d count %0d",
                       out_data.status, out_data.read_value, out_data.entry_count);
            end
          end
        end
        results_seen++;
      end
    end
    fail_count    <= fail_count + errors;
    pending_beats <= awaited_results.size();
    list_size     <= occupancy;
  end

endmodule

@@ test/testbench.sv @@
// Top of the indexed array list engine test: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import iale_pkg::*;

  // Code seven has no operation behind it; the block must treat it as a no-op.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_BEATS    = 230;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int pending_beats;
  int list_size;

  // Sender and receiver knobs, written by the stimulus process only.
  bit tx_free    = 1'b0;
  bit rx_free    = 1'b0;
  int hold_token = 0;

  // Receiver state, owned by the receiver process.
  int seen_token = 0;
  int rx_left    = 0;

  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_array_list_engine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  list_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_beats(pending_beats),
    .list_size    (list_size)
  );

  // Receiver: runs of ready and stalled cycles, mostly short with the odd long
  // one. A new hold token starts a long hold-off that this process counts out
  // itself while the sender keeps offering beats, so the block backs up.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_left   <= 0;
    end else if (hold_token != seen_token) begin
      seen_token <= hold_token;
      out_stall  <= 1'b1;
      rx_left    <= LONG_HOLD;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (rx_free) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        rx_left   <= $urandom_range(0, 6);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        rx_left   <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        rx_left   <= $urandom_range(10, 60);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t build_request(input logic [2:0] op, input int pos,
                                             input logic [31:0] word);
    in_item_t req;
    req.op         = op;
    req.position   = pos[7:0];
    req.item_value = word;
    return req;
  endfunction

  // Mostly in range for the current size, some anywhere in the field, some on
  // the edges: the front, the end, one past the end and the capacity.
  function automatic logic [7:0] pick_position(input int hint);
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      p = $urandom_range(0, hint);
    end else if (r < 85) begin
      p = $urandom_range(0, 255);
    end else begin
      case ($urandom_range(0, 3))
        0:       p = 0;
        1:       p = hint;
        2:       p = hint + 1;
        default: p = CAPACITY;
      endcase
    end
    return p[7:0];
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic in_item_t make_request(input mix_t mix, input int hint);
    in_item_t req;
    int       r;
    r              = $urandom_range(0, 99);
    req.item_value = pick_word();
    req.position   = pick_position(hint);
    case (mix)
      MIX_FILL: begin
        req.op = (r < 40) ? OP_PUSH_BACK : (r < 70) ? OP_PUSH_FRONT : OP_INSERT_AT;
        req.position = 8'($urandom_range(0, hint));
      end
      MIX_DRAIN: begin
        req.op = (r < 35) ? OP_POP_FRONT : (r < 70) ? OP_POP_BACK : OP_DELETE_AT;
        req.position = (hint > 0) ? 8'($urandom_range(0, hint - 1)) : 8'd0;
      end
      MIX_GROW: begin
        if (r < 30)      req.op = OP_PUSH_BACK;
        else if (r < 50) req.op = OP_PUSH_FRONT;
        else if (r < 75) req.op = OP_INSERT_AT;
        else if (r < 88) req.op = OP_READ;
        else             req.op = 3'($urandom_range(0, 7));
      end
      MIX_SHRINK: begin
        if (r < 25)      req.op = OP_POP_FRONT;
        else if (r < 50) req.op = OP_POP_BACK;
        else if (r < 75) req.op = OP_DELETE_AT;
        else if (r < 88) req.op = OP_READ;
        else             req.op = 3'($urandom_range(0, 7));
      end
      default: begin
        req.op = (r < 3) ? OP_UNUSED : 3'($urandom_range(0, 6));
      end
    endcase
    return req;
  endfunction

  // Offer one beat and hold it until it is taken. Valid stays high on return
  // so a back-to-back beat needs no second assignment in the same step.
  task automatic send_beat(input in_item_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid for a random gap: mostly none or short, now and then long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_free || r < 55)  n = 0;
    else if (r < 88)        n = $urandom_range(1, 3);
    else if (r < 97)        n = $urandom_range(4, 10);
    else                    n = $urandom_range(20, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_and_idle(input in_item_t req);
    send_beat(req);
    idle_gap();
  endtask

  // Stop offering and wait for every outstanding result. The first edge lets
  // the checker count the beat taken in this very step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  initial begin
    mix_t phase_mix [8];
    phase_mix = '{MIX_GROW, MIX_EVEN, MIX_EVEN, MIX_SHRINK,
                  MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_EVEN};

    // Hold reset first, then release it for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors on an empty list, the no-op code, extreme words, an
    // insert at the end and in the middle, reads past the end, deletes in the
    // middle and at the last entry, and both pops.
    send_and_idle(build_request(OP_POP_FRONT,  0,   32'h1111_1111));
    send_and_idle(build_request(OP_POP_BACK,   0,   32'h2222_2222));
    send_and_idle(build_request(OP_READ,       0,   32'h0));
    send_and_idle(build_request(OP_DELETE_AT,  0,   32'h0));
    send_and_idle(build_request(OP_INSERT_AT,  1,   32'h3333_3333));
    send_and_idle(build_request(OP_UNUSED,     0,   32'h4444_4444));
    send_and_idle(build_request(OP_INSERT_AT,  0,   32'h7fff_ffff));
    send_and_idle(build_request(OP_PUSH_FRONT, 0,   32'h8000_0000));
    send_and_idle(build_request(OP_PUSH_BACK,  0,   32'hffff_ffff));
    send_and_idle(build_request(OP_INSERT_AT,  3,   32'h0000_0000));
    send_and_idle(build_request(OP_INSERT_AT,  1,   32'h1234_5678));
    send_and_idle(build_request(OP_READ,       0,   32'h0));
    send_and_idle(build_request(OP_READ,       4,   32'h0));
    send_and_idle(build_request(OP_READ,       5,   32'h0));
    send_and_idle(build_request(OP_READ,       255, 32'hffff_ffff));
    send_and_idle(build_request(OP_DELETE_AT,  255, 32'h0));
    send_and_idle(build_request(OP_DELETE_AT,  2,   32'h0));
    send_and_idle(build_request(OP_DELETE_AT,  3,   32'h0));
    send_and_idle(build_request(OP_POP_FRONT,  0,   32'h0));
    send_and_idle(build_request(OP_POP_BACK,   0,   32'h0));
    send_and_idle(build_request(OP_UNUSED,     255, 32'hffff_ffff));
    send_and_idle(build_request(OP_INSERT_AT,  200, 32'h5555_5555));
    wait_drained();

    // Fill to capacity, then hit every full-list case: both pushes report
    // full, an insert reports bad index even at a legal position.
    while (list_size < CAPACITY) send_and_idle(make_request(MIX_FILL, list_size));
    send_and_idle(build_request(OP_PUSH_FRONT, 0,            pick_word()));
    send_and_idle(build_request(OP_PUSH_BACK,  0,            pick_word()));
    send_and_idle(build_request(OP_INSERT_AT,  0,            pick_word()));
    send_and_idle(build_request(OP_INSERT_AT,  CAPACITY,     pick_word()));
    send_and_idle(build_request(OP_READ,       CAPACITY - 1, 32'h0));
    send_and_idle(build_request(OP_READ,       CAPACITY,     32'h0));
    wait_drained();

    // Drain back to empty and knock on the empty list once more.
    while (list_size > 0) send_and_idle(make_request(MIX_DRAIN, list_size));
    send_and_idle(build_request(OP_POP_BACK,  0, 32'h0));
    send_and_idle(build_request(OP_POP_FRONT, 0, 32'h0));
    wait_drained();

    // Random phases, each leaning toward growth, shrinkage or an even mix.
    for (int phase = 0; phase < 8; phase++) begin
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // Phase two: hold the receiver off for a long stretch mid-phase.
        if (phase == 2 && k == 40) hold_token <= hold_token + 1;
        // Phase three: open with a stretch where neither side idles.
        if (phase == 3 && k == 0) begin
          tx_free <= 1'b1;
          rx_free <= 1'b1;
        end
        if (phase == 3 && k == 100) begin
          tx_free <= 1'b0;
          rx_free <= 1'b0;
        end
        send_and_idle(make_request(phase_mix[phase], list_size));
      end
      if (phase % 2 == 1) wait_drained();
    end

    // Let the last results out, then give the block a few spare cycles.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_beats == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
